FILE: src/opc_pkg.sv
// Shared types and constants of the opacity correction and premultiply unit.
`timescale 1ns / 1ps

package opc_pkg;

   localparam logic [15:0] Q15_ONE = 16'h8000;

   // Fraction bits of the log2 magnitude and of the exp2 argument
   localparam int LOG_FRAC = 28;
   // Normalized mantissa, Q1.30 held in 31 bits
   localparam int MANT_W = 31;
   // Log2 magnitude, integer part up to 15 plus LOG_FRAC fraction bits
   localparam int MAG_W = 32;
   // Integer part of the exp2 argument, 0 to 16
   localparam int EXP_N_W = 5;

   localparam int LOG_LATENCY = 30;
   localparam int EXP_LATENCY = 29;

   typedef struct packed {
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
      logic [15:0] alpha_in;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
      logic [15:0] alpha_out;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      CSR_PREMULTIPLY_ENABLE     = 2'd0,
      CSR_OPACITY_CORRECT_ENABLE = 2'd1,
      CSR_RATE_EXPONENT          = 2'd2
   } csr_index_type;

endpackage

FILE: src/opc_log2_pipe.sv
// Pipelined -log2(x / 32768) by repeated squaring of the normalized mantissa.
`timescale 1ns / 1ps

module opc_log2_pipe
   import opc_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [15:0]      x_in,
   output logic [MAG_W-1:0] mag_out
);

   logic [3:0]        norm_k;
   logic [MANT_W-1:0] norm_m;

   logic [MANT_W-1:0]   m_ff    [LOG_FRAC+1];
   logic [LOG_FRAC-1:0] frac_ff [LOG_FRAC+1];
   logic [3:0]          k_ff    [LOG_FRAC+1];
   logic [MAG_W-1:0]    mag_ff;

   // Highest set bit, capped at bit 14
   always_comb begin
      norm_k = '0;
      for (int b = 1; b < 15; b++) begin
         if (x_in[b]) begin
            norm_k = 4'(b);
         end
      end
      norm_m = {16'b0, x_in[14:0]} << (5'd30 - {1'b0, norm_k});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]    <= norm_m;
         k_ff[0]    <= norm_k;
         frac_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < LOG_FRAC; s++) begin : g_step
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     sq_top;
      logic                bit_set;

      assign sq      = m_ff[s] * m_ff[s];
      assign sq_top  = sq[2*MANT_W-1:MANT_W-1];
      assign bit_set = sq_top[MANT_W];

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[s+1]    <= bit_set ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
            frac_ff[s+1] <= {frac_ff[s][LOG_FRAC-2:0], bit_set};
            k_ff[s+1]    <= k_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= {4'd15 - k_ff[LOG_FRAC], {LOG_FRAC{1'b0}}}
                   - {{(MAG_W-LOG_FRAC){1'b0}}, frac_ff[LOG_FRAC]};
      end
   end

   assign mag_out = mag_ff;

endmodule

FILE: src/opc_exp2_pipe.sv
// Pipelined round(2^-t * 32768) by conditional multiplies with root-of-two constants.
`timescale 1ns / 1ps

module opc_exp2_pipe
   import opc_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [LOG_FRAC-1:0] f_in,
   input  logic [EXP_N_W-1:0]  n_in,
   output logic [15:0]         power_out
);

   localparam logic [31:0] P_ONE = 32'h8000_0000;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] b;
      rem = v;
      res = '0;
      b   = 64'h4000_0000_0000_0000;
      for (int j = 0; j < 32; j++) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-i) in Q0.32, by repeated square roots from 0.5
   function automatic logic [31:0] exp_coef(input int i);
      logic [63:0] c;
      c = 64'h0000_0000_8000_0000;
      for (int j = 0; j < i; j++) begin
         c = isqrt64(c << 32);
      end
      return c[31:0];
   endfunction

   logic [31:0]         p_ff [LOG_FRAC];
   logic [LOG_FRAC-1:0] f_ff [LOG_FRAC];
   logic [EXP_N_W-1:0]  n_ff [LOG_FRAC];
   logic [15:0]         power_ff;

   for (genvar s = 0; s < LOG_FRAC; s++) begin : g_step
      localparam logic [31:0] COEF = exp_coef(s + 1);
      logic [31:0]         p_src;
      logic [LOG_FRAC-1:0] f_src;
      logic [EXP_N_W-1:0]  n_src;
      logic [63:0]         prod;

      if (s == 0) begin : g_first
         assign p_src = P_ONE;
         assign f_src = f_in;
         assign n_src = n_in;
      end else begin : g_rest
         assign p_src = p_ff[s-1];
         assign f_src = f_ff[s-1];
         assign n_src = n_ff[s-1];
      end

      assign prod = p_src * COEF;

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[s] <= f_src[LOG_FRAC-1-s] ? prod[63:32] : p_src;
            f_ff[s] <= f_src;
            n_ff[s] <= n_src;
         end
      end
   end

   logic [5:0]  round_sh;
   logic [32:0] round_sum;
   logic [32:0] round_q;

   always_comb begin
      round_sh  = 6'd16 + {1'b0, n_ff[LOG_FRAC-1]};
      round_sum = {1'b0, p_ff[LOG_FRAC-1]} + (33'd1 << (round_sh - 6'd1));
      round_q   = round_sum >> round_sh;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         power_ff <= (round_q > {17'b0, Q15_ONE}) ? Q15_ONE : round_q[15:0];
      end
   end

   assign power_out = power_ff;

endmodule

FILE: src/opacity_correct_premultiply_unit.sv
// Opacity correction and premultiply of RGBA transfer-function entries in Q1.15.
// Each item is one RGBA entry (32768 means 1.0; larger inputs clamp to 1.0). With
// opacity correction on, alpha becomes 1 - (1 - alpha)^e, e being rate_exponent in
// unsigned Q4.12; the power is formed as exp2(e * log2(1 - alpha)) and lands within
// 2 LSB of exact. With premultiply on, red, green and blue are scaled by the new
// alpha, rounded half up. The unit takes one item every clock cycle unless a stalled
// result holds the pipeline. The depth comes from the 28-step squaring chain of the
// log2 and the 28-step multiply chain of the exp2, one 31-bit squaring or 32-bit
// multiply per stage. A stalled result holds the whole pipeline; one skid entry at
// the input absorbs the item that arrives as the stall takes hold, and req_stall
// comes straight from that entry's flag. csr_ready is always high; registers are to
// be written only while no item is in flight, which the unit itself does not enforce.
`timescale 1ns / 1ps

module opacity_correct_premultiply_unit
   import opc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,

   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,

   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,

   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_data
);

   typedef struct packed {
      logic        use_exp;
      logic [15:0] alpha_fixed;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } side_type;

   function automatic logic [15:0] sat_q15(input logic [15:0] v);
      return (v > Q15_ONE) ? Q15_ONE : v;
   endfunction

   function automatic logic [15:0] sat_q15_wide(input logic [16:0] v);
      return (v > {1'b0, Q15_ONE}) ? Q15_ONE : v[15:0];
   endfunction

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic        premultiply_enable_ff;
   logic        opacity_correct_enable_ff;
   logic [15:0] rate_exponent_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         premultiply_enable_ff     <= 1'b1;
         opacity_correct_enable_ff <= 1'b1;
         rate_exponent_ff          <= 16'd4096;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PREMULTIPLY_ENABLE:     premultiply_enable_ff     <= csr_data[0];
            CSR_OPACITY_CORRECT_ENABLE: opacity_correct_enable_ff <= csr_data[0];
            CSR_RATE_EXPONENT:          rate_exponent_ff          <= csr_data;
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Flow control: every stage advances together unless the result is stalled
   // ---------------------------------------------------------------------------------
   logic            adv;
   logic            accept;
   logic            skid_valid_ff;
   logic            skid_valid_in;
   req_payload_type skid_payload_ff;
   logic            src_valid;
   req_payload_type src_payload;
   logic            out_valid_ff;
   rsp_payload_type out_ff;

   assign adv       = !(out_valid_ff && rsp_stall);
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   // The skid entry, when full, always goes first
   assign src_valid   = skid_valid_ff || accept;
   assign src_payload = skid_valid_ff ? skid_payload_ff : req_payload;
   assign skid_valid_in = adv ? 1'b0 : (skid_valid_ff || accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !adv) begin
         skid_payload_ff <= req_payload;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 0: clamp the inputs to 1.0
   // ---------------------------------------------------------------------------------
   logic            s0_valid_ff;
   req_payload_type s0_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_pix_ff.red_in   <= sat_q15(src_payload.red_in);
         s0_pix_ff.green_in <= sat_q15(src_payload.green_in);
         s0_pix_ff.blue_in  <= sat_q15(src_payload.blue_in);
         s0_pix_ff.alpha_in <= sat_q15(src_payload.alpha_in);
      end
   end

   // ---------------------------------------------------------------------------------
   // Log2 of the transmittance 1 - alpha; the entry travels alongside
   // ---------------------------------------------------------------------------------
   logic [MAG_W-1:0]       log_mag;
   logic [LOG_LATENCY-1:0] lv_ff;
   req_payload_type        lp_ff [LOG_LATENCY];

   opc_log2_pipe u_log2 (
      .clock   (clock),
      .en      (adv),
      .x_in    (Q15_ONE - s0_pix_ff.alpha_in),
      .mag_out (log_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= '0;
      end else if (adv) begin
         lv_ff <= {lv_ff[LOG_LATENCY-2:0], s0_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lp_ff[0] <= s0_pix_ff;
         for (int i = 1; i < LOG_LATENCY; i++) begin
            lp_ff[i] <= lp_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Scale the log by the exponent: t = mag * e / 4096, Q.28
   // ---------------------------------------------------------------------------------
   localparam int T_W = MAG_W + 4;

   logic [MAG_W+15:0] t_prod;
   logic              t_valid_ff;
   logic [T_W-1:0]    t_ff;
   req_payload_type   t_pix_ff;

   assign t_prod = {16'b0, log_mag} * {{MAG_W{1'b0}}, rate_exponent_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (adv) begin
         t_valid_ff <= lv_ff[LOG_LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff     <= t_prod[MAG_W+15:12];
         t_pix_ff <= lp_ff[LOG_LATENCY-1];
      end
   end

   // ---------------------------------------------------------------------------------
   // Resolve the special cases; only the general case uses the exp2 result
   // ---------------------------------------------------------------------------------
   localparam logic [T_W-1:0] T_LIMIT = T_W'(17) << LOG_FRAC;

   side_type            d_side;
   logic                d_valid_ff;
   side_type            d_side_ff;
   logic [LOG_FRAC-1:0] d_f_ff;
   logic [EXP_N_W-1:0]  d_n_ff;

   always_comb begin
      d_side.red         = t_pix_ff.red_in;
      d_side.green       = t_pix_ff.green_in;
      d_side.blue        = t_pix_ff.blue_in;
      d_side.use_exp     = 1'b0;
      d_side.alpha_fixed = '0;
      if (!opacity_correct_enable_ff) begin
         d_side.alpha_fixed = t_pix_ff.alpha_in;
      end else if (rate_exponent_ff == '0) begin
         // zero exponent: the power is one, so alpha drops to zero
         d_side.alpha_fixed = '0;
      end else if (t_pix_ff.alpha_in == Q15_ONE) begin
         d_side.alpha_fixed = Q15_ONE;
      end else if (t_pix_ff.alpha_in == '0) begin
         d_side.alpha_fixed = '0;
      end else if (t_ff >= T_LIMIT) begin
         // power rounds to zero: fully opaque
         d_side.alpha_fixed = Q15_ONE;
      end else begin
         d_side.use_exp = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_side_ff <= d_side;
         d_f_ff    <= t_ff[LOG_FRAC-1:0];
         d_n_ff    <= t_ff[LOG_FRAC+EXP_N_W-1:LOG_FRAC];
      end
   end

   // ---------------------------------------------------------------------------------
   // Exp2 back to the power (1 - alpha)^e
   // ---------------------------------------------------------------------------------
   logic [15:0]            exp_power;
   logic [EXP_LATENCY-1:0] ev_ff;
   side_type               es_ff [EXP_LATENCY];

   opc_exp2_pipe u_exp2 (
      .clock     (clock),
      .en        (adv),
      .f_in      (d_f_ff),
      .n_in      (d_n_ff),
      .power_out (exp_power)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff <= '0;
      end else if (adv) begin
         ev_ff <= {ev_ff[EXP_LATENCY-2:0], d_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         es_ff[0] <= d_side_ff;
         for (int i = 1; i < EXP_LATENCY; i++) begin
            es_ff[i] <= es_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Final alpha
   // ---------------------------------------------------------------------------------
   logic        a_valid_ff;
   logic [15:0] a_alpha_ff;
   side_type    a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= ev_ff[EXP_LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff  <= es_ff[EXP_LATENCY-1];
         a_alpha_ff <= es_ff[EXP_LATENCY-1].use_exp ? (Q15_ONE - exp_power)
                                                    : es_ff[EXP_LATENCY-1].alpha_fixed;
      end
   end

   // ---------------------------------------------------------------------------------
   // Premultiply, rounded half up, into the output register
   // ---------------------------------------------------------------------------------
   logic [31:0] red_prod;
   logic [31:0] green_prod;
   logic [31:0] blue_prod;

   assign red_prod   = a_side_ff.red   * a_alpha_ff + 32'd16384;
   assign green_prod = a_side_ff.green * a_alpha_ff + 32'd16384;
   assign blue_prod  = a_side_ff.blue  * a_alpha_ff + 32'd16384;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (premultiply_enable_ff) begin
            out_ff.red_out   <= sat_q15_wide(red_prod[31:15]);
            out_ff.green_out <= sat_q15_wide(green_prod[31:15]);
            out_ff.blue_out  <= sat_q15_wide(blue_prod[31:15]);
         end else begin
            out_ff.red_out   <= a_side_ff.red;
            out_ff.green_out <= a_side_ff.green;
            out_ff.blue_out  <= a_side_ff.blue;
         end
         out_ff.alpha_out <= a_alpha_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------

   // The skid entry only fills on a cycle where the pipeline held
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !$past(adv))
      else $error("skid entry filled while the pipeline advanced");

   // Every result component stays within [0, 1.0]
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.alpha_out <= Q15_ONE) && (rsp_payload.red_out <= Q15_ONE)
                    && (rsp_payload.green_out <= Q15_ONE)
                    && (rsp_payload.blue_out <= Q15_ONE))
      else $error("result component above 1.0");

   // The exp2 power never exceeds 1.0, so the corrected alpha cannot wrap
   a_power_range: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> a_alpha_ff <= Q15_ONE)
      else $error("corrected alpha out of range");

endmodule

FILE: bench/opacity_correct_premultiply_unit_test.sv
// Self-checking bench for the opacity correction and premultiply unit.
`timescale 1ns / 1ps

module opacity_correct_premultiply_unit_test;
   import opc_pkg::*;

   // Index 3 is not a register; writes to it must leave every setting alone.
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   // Result depth of the unit plus margin, for the quiet wait at the end.
   localparam int DRAIN_CYCLES = 80;
   // Far beyond the slowest legal run.
   localparam longint RUN_LIMIT_NS = 64'd5_000_000;
   localparam int SEGMENT_ITEMS = 50;
   localparam int SEGMENTS = 8;

   // Predicts each RGBA entry and holds the results still owed by the unit.
   class entry_scoreboard;
      bit              premul_on;
      bit              correct_on;
      logic [15:0]     exponent;
      rsp_payload_type pending[$];
      int              mismatches;
      // exp2_step[i] = 2^(-2^-i) in Q0.32, built by repeated square roots.
      logic [63:0]     exp2_step[1:28];

      function new();
         logic [63:0] root;
         int          i;
         premul_on  = 1'b1;
         correct_on = 1'b1;
         exponent   = 16'd4096;
         mismatches = 0;
         root = 64'h8000_0000;
         for (i = 1; i <= LOG_FRAC; i++) begin
            root = int_sqrt(root << 32);
            exp2_step[i] = root;
         end
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] v);
         logic [63:0] rem;
         logic [63:0] res;
         logic [63:0] place;
         rem   = v;
         res   = '0;
         place = 64'd1 << 62;
         while (place > rem) place >>= 2;
         while (place != 0) begin
            if (rem >= res + place) begin
               rem = rem - (res + place);
               res = (res >> 1) + place;
            end else begin
               res >>= 1;
            end
            place >>= 2;
         end
         return res;
      endfunction

      function logic [15:0] clamp_unit(logic [63:0] v);
         return (v > 64'(Q15_ONE)) ? Q15_ONE : v[15:0];
      endfunction

      // -log2(x / 32768) with 28 fraction bits, x in [1, 32767].
      function logic [63:0] log2_magnitude(logic [15:0] x);
         logic [63:0] m;
         logic [63:0] frac;
         logic [63:0] whole;
         int          k;
         int          i;
         k = 0;
         for (i = 0; i <= 14; i++) if (x[i]) k = i;
         m = 64'(x) << (30 - k);
         frac = '0;
         for (i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
               frac = frac | 64'd1;
               m = m >> 1;
            end
         end
         whole = 64'(15 - k);
         return (whole << LOG_FRAC) - frac;
      endfunction

      // round(2^-t * 32768), t in Q.28 below 17.0.
      function logic [15:0] power_q15(logic [63:0] t);
         logic [63:0] p;
         int          n;
         int          sh;
         int          i;
         n = int'(t >> LOG_FRAC);
         p = 64'h8000_0000;
         for (i = 1; i <= LOG_FRAC; i++)
            if (t[LOG_FRAC - i]) p = (p * exp2_step[i]) >> 32;
         sh = 16 + n;
         return clamp_unit((p + (64'd1 << (sh - 1))) >> sh);
      endfunction

      function logic [15:0] corrected_alpha(logic [15:0] a);
         logic [63:0] t;
         logic [63:0] e;
         if (exponent == 16'd0) return 16'd0;
         if (a >= Q15_ONE) return Q15_ONE;
         if (a == 16'd0) return 16'd0;
         e = 64'(exponent);
         t = (log2_magnitude(Q15_ONE - a) * e) >> 12;
         if (t >= (64'd17 << LOG_FRAC)) return Q15_ONE;
         return Q15_ONE - power_q15(t);
      endfunction

      function logic [15:0] scale_color(logic [15:0] c, logic [15:0] a);
         logic [63:0] prod;
         prod = 64'(c) * 64'(a) + 64'd16384;
         return clamp_unit(prod >> 15);
      endfunction

      function rsp_payload_type premultiplied_entry(req_payload_type item);
         rsp_payload_type res;
         res.red_out   = clamp_unit(64'(item.red_in));
         res.green_out = clamp_unit(64'(item.green_in));
         res.blue_out  = clamp_unit(64'(item.blue_in));
         res.alpha_out = clamp_unit(64'(item.alpha_in));
         if (correct_on) res.alpha_out = corrected_alpha(res.alpha_out);
         if (premul_on) begin
            res.red_out   = scale_color(res.red_out, res.alpha_out);
            res.green_out = scale_color(res.green_out, res.alpha_out);
            res.blue_out  = scale_color(res.blue_out, res.alpha_out);
         end
         return res;
      endfunction

      function void write_register(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_PREMULTIPLY_ENABLE: begin
               premul_on = data[0];
            end
            CSR_OPACITY_CORRECT_ENABLE: begin
               correct_on = data[0];
            end
            CSR_RATE_EXPONENT: begin
               exponent = data;
            end
            default: begin
            end
         endcase
      endfunction

      function void note_entry(req_payload_type item);
         pending.push_back(premultiplied_entry(item));
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_entry(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            $error("result with no item outstanding: %h", got);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         compare_field("red_out", want.red_out, got.red_out);
         compare_field("green_out", want.green_out, got.green_out);
         compare_field("blue_out", want.blue_out, got.blue_out);
         compare_field("alpha_out", want.alpha_out, got.alpha_out);
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = '0;
   logic [15:0]     csr_data = '0;

   // Percent of cycles in which the source holds off and the sink stalls.
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   entry_scoreboard board = new();

   opacity_correct_premultiply_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the unit hangs or drops a result.
   initial begin
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // Sink side: redraw the stall once per cycle, so stalls land on any pipeline phase.
   always @(posedge clock) begin
      rsp_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   // Observe the handshakes with the values that were present at the edge. Register
   // writes update the predictor's settings at the same edge the unit takes them.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_register(csr_index, csr_data);
         if (req_valid && !req_stall) board.note_entry(req_payload);
         if (rsp_valid && !rsp_stall) board.check_entry(rsp_payload);
      end
   end

   function automatic req_payload_type make_entry(int r, int g, int b, int a);
      req_payload_type item;
      item.red_in   = 16'(r);
      item.green_in = 16'(g);
      item.blue_in  = 16'(b);
      item.alpha_in = 16'(a);
      return item;
   endfunction

   // Bias toward the edges of the range: zero, one, above one, near zero and near one
   // all steer alpha into distinct branches of the correction.
   function automatic logic [15:0] random_channel();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return Q15_ONE;
         2: return 16'($urandom_range(32769, 65535));
         3: return 16'($urandom_range(1, 64));
         4: return 16'($urandom_range(32700, 32767));
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   // Present one item, after an optional hold-off, and hold it until taken.
   // Leave valid high on return so back-to-back items flow without a bubble.
   task automatic send_entry(input req_payload_type item);
      if ((sender_idle_pct > 0) && ($urandom_range(99) < sender_idle_pct)) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every outstanding item has come back. Wait for an edge
   // first so the item taken at the last edge is already on the pending list.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Register write; call only with the pipeline empty.
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   initial begin
      logic [15:0] rate;
      int          seg;
      int          n;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset settings (both enables on, exponent 1.0):
      // transparent, fully opaque, above-one clamping, alpha one LSB off each end.
      send_entry(make_entry(0, 0, 0, 0));
      send_entry(make_entry(32768, 32768, 32768, 32768));
      send_entry(make_entry(65535, 65535, 65535, 65535));
      send_entry(make_entry(12345, 32768, 0, 1));
      send_entry(make_entry(32768, 16384, 1, 32767));
      send_entry(make_entry(100, 20000, 30000, 16384));
      settle_pipeline();

      // Zero exponent: the power is one, so alpha collapses to zero even when opaque.
      write_csr(CSR_RATE_EXPONENT, 16'd0);
      send_entry(make_entry(32768, 32768, 32768, 16384));
      send_entry(make_entry(1000, 2000, 3000, 32768));
      send_entry(make_entry(1000, 2000, 3000, 0));
      settle_pipeline();

      // Largest exponent: the power shrinks, and for alpha near one it underflows and alpha saturates to one.
      write_csr(CSR_RATE_EXPONENT, 16'hFFFF);
      send_entry(make_entry(32768, 16000, 8000, 100));
      send_entry(make_entry(32768, 16000, 8000, 16384));
      send_entry(make_entry(32768, 16000, 8000, 32767));
      settle_pipeline();

      // Smallest nonzero exponent.
      write_csr(CSR_RATE_EXPONENT, 16'd1);
      send_entry(make_entry(32768, 16000, 8000, 20000));
      settle_pipeline();

      // Correction off; upper data bits set but bit 0 clear, so only bit 0 counts.
      write_csr(CSR_OPACITY_CORRECT_ENABLE, 16'hFFFE);
      send_entry(make_entry(30000, 20000, 10000, 24000));
      send_entry(make_entry(65535, 40000, 32769, 40000));
      settle_pipeline();

      // Premultiply off, correction back on, exponent 2.0.
      write_csr(CSR_PREMULTIPLY_ENABLE, 16'h0000);
      write_csr(CSR_OPACITY_CORRECT_ENABLE, 16'h0001);
      write_csr(CSR_RATE_EXPONENT, 16'd8192);
      send_entry(make_entry(30000, 20000, 10000, 24000));
      send_entry(make_entry(32768, 1, 65535, 8000));
      settle_pipeline();

      // A write to the unused index must change nothing.
      write_csr(CSR_UNUSED_INDEX, 16'hFFFF);
      send_entry(make_entry(30000, 20000, 10000, 24000));
      settle_pipeline();

      // Random segments: new settings each time, cycling through the idling modes.
      // Each segment ends with the source paused until everything has returned.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: set_idling(0, 0);
            1: set_idling(82, 0);
            2: set_idling(0, 82);
            default: set_idling(26, 26);
         endcase
         case ($urandom_range(5))
            0: rate = 16'd0;
            1: rate = 16'hFFFF;
            2: rate = 16'd4096;
            3: rate = 16'($urandom_range(1, 255));
            default: rate = 16'($urandom_range(0, 65535));
         endcase
         // Random data words: only bit 0 lands in the enables, the rest toggles the bus.
         write_csr(CSR_PREMULTIPLY_ENABLE, 16'($urandom_range(0, 65535)));
         write_csr(CSR_OPACITY_CORRECT_ENABLE, 16'($urandom_range(0, 65535)));
         write_csr(CSR_RATE_EXPONENT, rate);
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            send_entry({random_channel(), random_channel(), random_channel(),
                        random_channel()});
         end
         settle_pipeline();
      end

      // Stay quiet for a full pipeline depth to catch any stray result.
      set_idling(0, 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending.size() != 0) begin
         $error("%0d expected results never arrived", board.pending.size());
      end
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
src/opc_pkg.sv
src/opc_log2_pipe.sv
src/opc_exp2_pipe.sv
src/opacity_correct_premultiply_unit.sv
bench/opacity_correct_premultiply_unit_test.sv
